>>> design/vfp_pkg.sv
// Shared types and constants for the vision frame parser.
// Used by the front, queue, back and top-level modules.
package vfp_pkg;

  localparam int FRAME_DEPTH_DEF = 10;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int BYTE_W          = 8;
  localparam int VAL_W           = 24;
  localparam int PAYLOAD_BYTES   = 6;

  localparam logic [BYTE_W-1:0] START_BYTE_RST = 8'h73;
  localparam logic [BYTE_W-1:0] END_BYTE_RST   = 8'h65;

  typedef enum logic [0:0] {
    CFG_START_BYTE = 1'b0,
    CFG_END_BYTE   = 1'b1
  } cfg_index_t;

  // byte at frame position i+1 sits in element i
  typedef logic [PAYLOAD_BYTES-1:0][BYTE_W-1:0] frame_t;

endpackage

>>> design/vision_frame_parser_core.sv
// Vision frame parser: one received byte per cycle, in_stall only while the frame queue is full.
// After its end byte, a result passes the queue, scale and round registers; a stall can hold it.
// The queue holds QUEUE_DEPTH finished frames; decode takes one frame per cycle unless stalled.
// Synchronous active-low reset: idle hunting for start, counter and payload bytes cleared,
// start byte 0x73, end byte 0x65, queue and pipeline empty.
module vision_frame_parser_core #(
  parameter int FRAME_DEPTH = vfp_pkg::FRAME_DEPTH_DEF,
  parameter int QUEUE_DEPTH = vfp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [0:0]                       cfg_index,
  input  logic [vfp_pkg::BYTE_W-1:0]       cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [vfp_pkg::BYTE_W-1:0]       in_rx_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [vfp_pkg::VAL_W-1:0] out_pitch_value,
  output logic signed [vfp_pkg::VAL_W-1:0] out_yaw_value,
  output logic signed [vfp_pkg::VAL_W-1:0] out_distance_value
);

  vfp_pkg::frame_t push_frame, pop_frame;
  logic            q_push, q_full;
  logic            in_accept, q_pop, q_not_empty;

  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  vfp_front #(.FRAME_DEPTH(FRAME_DEPTH)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_accept  (in_accept),
    .in_rx_byte (in_rx_byte),
    .push       (q_push),
    .push_frame (push_frame)
  );

  vfp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_frame (push_frame),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .pop_frame  (pop_frame)
  );

  vfp_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_not_empty        (q_not_empty),
    .q_frame            (pop_frame),
    .q_pop              (q_pop),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_pitch_value    (out_pitch_value),
    .out_yaw_value      (out_yaw_value),
    .out_distance_value (out_distance_value)
  );

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("frame pushed into a full queue");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty)
    else $error("frame popped from an empty queue");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !q_not_empty)
    else $error("result or queued frame survives reset");

endmodule

>>> design/vfp_front.sv
// Frame assembly: start/end byte detection, byte counter and payload bytes.
// Depends on vfp_pkg; pushes finished frames into vfp_queue.
module vfp_front #(
  parameter int FRAME_DEPTH = vfp_pkg::FRAME_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [vfp_pkg::BYTE_W-1:0] cfg_data,
  input  logic                      in_accept,
  input  logic [vfp_pkg::BYTE_W-1:0] in_rx_byte,
  output logic                      push,
  output vfp_pkg::frame_t           push_frame
);

  localparam int CW = $clog2(FRAME_DEPTH + 1);

  logic [vfp_pkg::BYTE_W-1:0] start_byte_r, end_byte_r;
  logic                       collecting_r, collecting_nxt;
  logic [CW-1:0]              count_r, count_nxt, count_inc;
  vfp_pkg::frame_t            store_r, store_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= vfp_pkg::START_BYTE_RST;
      end_byte_r   <= vfp_pkg::END_BYTE_RST;
    end else if (cfg_we) begin
      unique case (vfp_pkg::cfg_index_t'(cfg_index))
        vfp_pkg::CFG_START_BYTE: start_byte_r <= cfg_data;
        vfp_pkg::CFG_END_BYTE:   end_byte_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    collecting_nxt = collecting_r;
    count_nxt      = count_r;
    store_nxt      = store_r;
    push           = 1'b0;
    count_inc      = count_r + CW'(1);
    if (in_accept) begin
      if (!collecting_r) begin
        if (in_rx_byte == start_byte_r) begin
          collecting_nxt = 1'b1;
          count_nxt      = CW'(1);
        end
      end else begin
        for (int i = 0; i < vfp_pkg::PAYLOAD_BYTES; i++) begin
          if (count_r == CW'(i + 1)) store_nxt[i] = in_rx_byte;
        end
        if (in_rx_byte == end_byte_r) begin
          push           = 1'b1;
          collecting_nxt = 1'b0;
          count_nxt      = '0;
        end else if (count_inc >= CW'(FRAME_DEPTH)) begin
          // drop: buffer full with no end byte
          collecting_nxt = 1'b0;
          count_nxt      = '0;
        end else begin
          count_nxt = count_inc;
        end
      end
    end
  end

  assign push_frame = store_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r <= 1'b0;
      count_r      <= '0;
      store_r      <= '0;
    end else begin
      collecting_r <= collecting_nxt;
      count_r      <= count_nxt;
      store_r      <= store_nxt;
    end
  end

endmodule

>>> design/vfp_queue.sv
// Short frame queue between the front and the decode back end.
// Depends on vfp_pkg for the frame type.
module vfp_queue #(
  parameter int DEPTH = vfp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  vfp_pkg::frame_t push_frame,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output vfp_pkg::frame_t pop_frame
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  vfp_pkg::frame_t mem [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full      = (count_r == NW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_frame = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    if (do_pop)  rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    if (do_push && !do_pop) count_nxt = count_r + NW'(1);
    if (!do_push && do_pop) count_nxt = count_r - NW'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= push_frame;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> design/vfp_back.sv
// Decode back end: two-stage scaling of three words to signed Q16 values.
// Depends on vfp_pkg; pops frames from vfp_queue and drives the result register.
module vfp_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_not_empty,
  input  vfp_pkg::frame_t                  q_frame,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [vfp_pkg::VAL_W-1:0] out_pitch_value,
  output logic signed [vfp_pkg::VAL_W-1:0] out_yaw_value,
  output logic signed [vfp_pkg::VAL_W-1:0] out_distance_value
);

  localparam int NW  = 3;
  localparam int KW  = 15;
  localparam int PW  = 23;
  localparam int VW  = vfp_pkg::VAL_W;
  localparam logic [KW-1:0] M_MAX = 15'h7fff;

  logic                 en;
  logic                 s1_valid_r, out_valid_r;
  logic [NW-1:0]        neg_r;
  logic [NW-1:0][PW-1:0] k200_r;
  logic [NW-1:0]        neg_nxt;
  logic [NW-1:0][PW-1:0] k200_nxt;
  logic [NW-1:0][VW-1:0] val_nxt, val_r;

  assign en    = !out_valid_r || !out_stall;
  assign q_pop = en && q_not_empty;

  // k * 200, where k is m or 32767 - m
  always_comb begin
    logic [15:0] w;
    logic [KW-1:0] k;
    for (int n = 0; n < NW; n++) begin
      w           = {q_frame[2*n], q_frame[2*n+1]};
      k           = w[15] ? (M_MAX - w[KW-1:0]) : w[KW-1:0];
      neg_nxt[n]  = w[15];
      k200_nxt[n] = PW'(k) * PW'(200);
    end
  end

  // round(k * 6553600 / 32767) = k*200 + floor((k*200 + 16383) / 32767)
  always_comb begin
    logic [VW-1:0] j, qs, mag;
    for (int n = 0; n < NW; n++) begin
      j          = {1'b0, k200_r[n]} + VW'(16383);
      qs         = j + VW'(j[VW-1:15]) + VW'(1);
      mag        = {1'b0, k200_r[n]} + VW'(qs[VW-1:15]);
      val_nxt[n] = neg_r[n] ? (VW'(0) - mag) : mag;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r  <= neg_nxt;
      k200_r <= k200_nxt;
    end
    if (en && s1_valid_r) val_r <= val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= q_not_empty;
      out_valid_r <= s1_valid_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_pitch_value    = val_r[0];
  assign out_yaw_value      = val_r[1];
  assign out_distance_value = val_r[2];

endmodule
